// ===== hdl/scdr_pkg.sv =====
// Shared types, codes and reply byte lookup for the serial command deframer.
`default_nettype none
package scdr_pkg;

  // Parser phases
  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_VERSION = 3'd1;
  localparam logic [2:0] PH_CMD     = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_LEN_LO  = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;

  localparam logic [7:0] SYNC_0       = 8'hC1;
  localparam logic [7:0] SYNC_1       = 8'h1F;
  localparam logic [7:0] SYNC_2       = 8'hFE;
  localparam logic [7:0] SYNC_3       = 8'h72;
  localparam logic [7:0] VERSION_BYTE = 8'd2;

  localparam logic [7:0] CODE_CHANNEL       = 8'h01;
  localparam logic [7:0] CODE_CHANNEL_MIN   = 8'h02;
  localparam logic [7:0] CODE_CHANNEL_MAX   = 8'h03;
  localparam logic [7:0] CODE_NOT_SUPPORTED = 8'h7F;

  localparam logic [7:0] OP_GET_CHANNEL = 8'h81;
  localparam logic [7:0] OP_GET_MIN     = 8'h82;
  localparam logic [7:0] OP_GET_MAX     = 8'h83;
  localparam logic [7:0] OP_SET_CHANNEL = 8'h84;

  // Configuration register indexes
  localparam logic REG_CHANNEL_MIN = 1'b0;
  localparam logic REG_CHANNEL_MAX = 1'b1;

  // Byte positions within a reply frame
  localparam logic [3:0] POS_SYNC_0  = 4'd0;
  localparam logic [3:0] POS_SYNC_1  = 4'd1;
  localparam logic [3:0] POS_SYNC_2  = 4'd2;
  localparam logic [3:0] POS_SYNC_3  = 4'd3;
  localparam logic [3:0] POS_VERSION = 4'd4;
  localparam logic [3:0] POS_CODE    = 4'd5;
  localparam logic [3:0] POS_LEN_HI  = 4'd6;
  localparam logic [3:0] POS_LEN_LO  = 4'd7;
  localparam logic [3:0] POS_VALUE   = 4'd8;

  // One queued reply: header code and optional value byte
  typedef struct packed {
    logic [7:0] code;
    logic       has_value;
    logic [7:0] value;
  } reply_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = SYNC_0;
      2'd1:    b = SYNC_1;
      2'd2:    b = SYNC_2;
      default: b = SYNC_3;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] reply_byte_at(input reply_t r, input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      POS_SYNC_0:  b = SYNC_0;
      POS_SYNC_1:  b = SYNC_1;
      POS_SYNC_2:  b = SYNC_2;
      POS_SYNC_3:  b = SYNC_3;
      POS_VERSION: b = VERSION_BYTE;
      POS_CODE:    b = r.code;
      POS_LEN_HI:  b = 8'd0;
      POS_LEN_LO:  b = {7'd0, r.has_value};
      default:     b = r.value;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/serial_command_deframer_responder.sv =====
// Top level of the serial command deframer and responder.
// Takes one host byte or timeout event per cycle while the two-entry reply queue has room;
// the parser answers get commands on the command byte and other commands on the data byte.
// Each reply leaves as 8 bytes (not-supported) or 9 bytes (with a value), one byte per cycle
// from the serializer while out_stall is low, and input stalls only
// when two replies are already waiting. channel_min and channel_max reset to 11 and 26, the
// channel to 26; register writes are registered and never move the stored channel.
`default_nettype none
module serial_command_deframer_responder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic       wr_index,
  input  wire logic [7:0] wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       func,
  input  wire logic [7:0] byte_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      reply_byte,
  output logic            last
);

  logic                accept;
  logic                push;
  logic                pop;
  scdr_pkg::reply_t    push_data;
  scdr_pkg::reply_t    head;
  scdr_pkg::q_status_t q_st;

  assign in_stall = q_st.full;
  assign accept   = in_valid && !in_stall;

  scdr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .accept     (accept),
    .func       (func),
    .byte_value (byte_value),
    .push       (push),
    .push_data  (push_data)
  );

  scdr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_st)
  );

  scdr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_st.valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reply_byte (reply_byte),
    .last       (last)
  );

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_st.full)
    else $error("reply pushed into full queue");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_st.valid)
    else $error("reply popped from empty queue");

  // output never goes idle mid-frame, so a new burst opens with the first sync byte
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> reply_byte == scdr_pkg::SYNC_0)
    else $error("reply burst does not start with sync byte");

endmodule
`default_nettype wire

// ===== hdl/scdr_front.sv =====
// Front end: frame parser, configuration registers and reply selection.
`default_nettype none
module scdr_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic             wr_index,
  input  wire logic [7:0]       wr_data,
  input  wire logic             accept,
  input  wire logic             func,
  input  wire logic [7:0]       byte_value,
  output logic                  push,
  output scdr_pkg::reply_t      push_data
);

  logic [2:0] phase, phase_next;
  logic [1:0] magic_matched, magic_matched_next;
  logic [7:0] pending_command, pending_command_next;
  logic [7:0] length_high, length_high_next;
  logic [7:0] current_channel, current_channel_next;
  logic [7:0] channel_min;
  logic [7:0] channel_max;

  function automatic scdr_pkg::reply_t run_cmd(input logic [7:0] cmd, input logic [7:0] data,
                                               input logic [7:0] cur, input logic [7:0] mn,
                                               input logic [7:0] mx);
    scdr_pkg::reply_t r;
    r.has_value = 1'b1;
    case (cmd)
      scdr_pkg::OP_GET_CHANNEL: begin
        r.code  = scdr_pkg::CODE_CHANNEL;
        r.value = cur;
      end
      scdr_pkg::OP_GET_MIN: begin
        r.code  = scdr_pkg::CODE_CHANNEL_MIN;
        r.value = mn;
      end
      scdr_pkg::OP_GET_MAX: begin
        r.code  = scdr_pkg::CODE_CHANNEL_MAX;
        r.value = mx;
      end
      scdr_pkg::OP_SET_CHANNEL: begin
        if (data >= mn && data <= mx) begin
          r.code  = scdr_pkg::CODE_CHANNEL;
          r.value = data;
        end else begin
          r.code      = scdr_pkg::CODE_NOT_SUPPORTED;
          r.has_value = 1'b0;
          r.value     = 8'd0;
        end
      end
      default: begin
        r.code      = scdr_pkg::CODE_NOT_SUPPORTED;
        r.has_value = 1'b0;
        r.value     = 8'd0;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    phase_next           = phase;
    magic_matched_next   = magic_matched;
    pending_command_next = pending_command;
    length_high_next     = length_high;
    current_channel_next = current_channel;
    push                 = 1'b0;
    push_data            = run_cmd(pending_command, byte_value, current_channel,
                                   channel_min, channel_max);
    if (accept) begin
      if (func) begin
        // timeout: drop the partial frame
        phase_next           = scdr_pkg::PH_MAGIC;
        magic_matched_next   = 2'd0;
        pending_command_next = 8'd0;
        length_high_next     = 8'd0;
      end else begin
        case (phase)
          scdr_pkg::PH_VERSION: begin
            if (byte_value == scdr_pkg::VERSION_BYTE) begin
              phase_next = scdr_pkg::PH_CMD;
            end else begin
              phase_next           = scdr_pkg::PH_MAGIC;
              magic_matched_next   = 2'd0;
              pending_command_next = 8'd0;
              length_high_next     = 8'd0;
            end
          end
          scdr_pkg::PH_CMD: begin
            if (byte_value inside {scdr_pkg::OP_GET_CHANNEL, scdr_pkg::OP_GET_MIN,
                                   scdr_pkg::OP_GET_MAX}) begin
              push                 = 1'b1;
              push_data            = run_cmd(byte_value, 8'd0, current_channel,
                                             channel_min, channel_max);
              phase_next           = scdr_pkg::PH_MAGIC;
              magic_matched_next   = 2'd0;
              pending_command_next = 8'd0;
              length_high_next     = 8'd0;
            end else begin
              pending_command_next = byte_value;
              phase_next           = scdr_pkg::PH_LEN_HI;
            end
          end
          scdr_pkg::PH_LEN_HI: begin
            length_high_next = byte_value;
            phase_next       = scdr_pkg::PH_LEN_LO;
          end
          scdr_pkg::PH_LEN_LO: begin
            if (length_high == 8'd0 && byte_value == 8'd1) begin
              phase_next = scdr_pkg::PH_DATA;
            end else begin
              phase_next           = scdr_pkg::PH_MAGIC;
              magic_matched_next   = 2'd0;
              pending_command_next = 8'd0;
              length_high_next     = 8'd0;
            end
          end
          scdr_pkg::PH_DATA: begin
            push = 1'b1;
            if (pending_command == scdr_pkg::OP_SET_CHANNEL &&
                byte_value >= channel_min && byte_value <= channel_max) begin
              current_channel_next = byte_value;
            end
            phase_next           = scdr_pkg::PH_MAGIC;
            magic_matched_next   = 2'd0;
            pending_command_next = 8'd0;
            length_high_next     = 8'd0;
          end
          default: begin
            // waiting for magic; a mismatched byte is not rechecked
            if (byte_value == scdr_pkg::sync_byte(magic_matched)) begin
              if (magic_matched == 2'd3) begin
                phase_next         = scdr_pkg::PH_VERSION;
                magic_matched_next = 2'd0;
              end else begin
                phase_next         = scdr_pkg::PH_MAGIC;
                magic_matched_next = magic_matched + 2'd1;
              end
            end else begin
              phase_next           = scdr_pkg::PH_MAGIC;
              magic_matched_next   = 2'd0;
              pending_command_next = 8'd0;
              length_high_next     = 8'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= scdr_pkg::PH_MAGIC;
      magic_matched   <= 2'd0;
      pending_command <= 8'd0;
      length_high     <= 8'd0;
      current_channel <= 8'd26;
      channel_min     <= 8'd11;
      channel_max     <= 8'd26;
    end else begin
      phase           <= phase_next;
      magic_matched   <= magic_matched_next;
      pending_command <= pending_command_next;
      length_high     <= length_high_next;
      current_channel <= current_channel_next;
      if (wr_en) begin
        if (wr_index == scdr_pkg::REG_CHANNEL_MIN) begin
          channel_min <= wr_data;
        end else begin
          channel_max <= wr_data;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scdr_queue.sv =====
// Two-entry reply queue between the parser and the byte serializer.
`default_nettype none
module scdr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire scdr_pkg::reply_t   push_data,
  input  wire logic               pop,
  output scdr_pkg::reply_t        head,
  output scdr_pkg::q_status_t     status
);

  scdr_pkg::reply_t entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign head         = entry[rptr];
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scdr_back.sv =====
// Back end: serializes the queued reply at the head into frame bytes.
`default_nettype none
module scdr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire scdr_pkg::reply_t   head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              reply_byte,
  output logic                    last
);

  logic [3:0] pos;
  logic       load;
  logic       last_now;

  // output register is free when empty or being taken this cycle
  assign load     = q_valid && (!out_valid || !out_stall);
  assign last_now = head.has_value ? (pos == scdr_pkg::POS_VALUE)
                                   : (pos == scdr_pkg::POS_LEN_LO);
  assign pop      = load && last_now;

  always_ff @(posedge clk) begin
    if (load) begin
      reply_byte <= scdr_pkg::reply_byte_at(head, pos);
      last       <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= scdr_pkg::POS_SYNC_0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= last_now ? scdr_pkg::POS_SYNC_0 : pos + 4'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
